/* design/apct_pkg.sv */
package apct_pkg;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_APPEND  = 2'd1,
      OP_COLLIDE = 2'd2,
      OP_QUERY   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRIG,
      ST_READ,
      ST_TEST,
      ST_DONE
   } state_type;

   localparam logic [1:0] REG_AREA   = 2'd0;
   localparam logic [1:0] REG_MARGIN = 2'd1;
   localparam logic [1:0] REG_FLOOR  = 2'd2;

   localparam logic [7:0] DIM_W [2] = '{8'd195, 8'd35};
   localparam logic [7:0] DIM_D [2] = '{8'd70, 8'd40};
   localparam logic [7:0] DIM_H [2] = '{8'd100, 8'd176};

   // one table entry: x, y, z, half x, half z, height
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic [8:0]         hx;
      logic [8:0]         hz;
      logic [7:0]         h;
   } prop_type;

endpackage

/* design/aabb_prop_collision_table.sv */
// Clear empties the table; append runs the three-stage sine pipeline, then the
// table write; collide and query do one table read and one test per prop (a query
// stops at its first hit; with area_enabled 0 no prop is tested). One item in
// flight: the next beat is taken once the result is registered and the state
// returns to idle.
// Reset (synchronous): table empty, area_enabled 1, push_margin 30, floor_offset 0.
module aabb_prop_collision_table #(
   parameter int MAX_PROPS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op[1:0], model[2], pos_x[18:3], pos_y[34:19], pos_z[50:35], rotation[62:51],
   // radius[74:63], slack[86:75], zero pad
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // new_x[15:0], new_z[31:16], solid_hit[32], append_dropped[33], props_held[40:34]
   output logic [47:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int AW = (MAX_PROPS > 1) ? $clog2(MAX_PROPS) : 1;

   apct_pkg::state_type state_ff, state_in;
   logic [1:0]          op_ff;
   logic                model_ff;
   logic signed [15:0]  px_ff, py_ff, pz_ff;
   logic [11:0]         rot_ff, rad_ff, slk_ff;
   logic signed [18:0]  nx_ff, nx_in, nz_ff, nz_in;
   logic                hit_ff, hit_in, drop_ff, drop_in;
   logic [6:0]          total_ff, total_in, idx_ff, idx_in;
   logic [1:0]          calc_ff, calc_in;
   logic                area_ff;
   logic [7:0]          margin_ff;
   logic signed [15:0]  floor_ff;
   logic                out_v_ff, out_v_in;
   logic [47:0]         out_d_ff, out_d_in;
   logic                wr_en;
   apct_pkg::prop_type  wr_data, rd_data;
   logic [8:0]          hx, hz;
   logic                cfg_wr;

   // saturation
   function automatic logic [15:0] sat16(input logic signed [18:0] v);
      if (v > 19'sd32767) sat16 = 16'h7fff;
      else if (v < -19'sd32768) sat16 = 16'h8000;
      else sat16 = v[15:0];
   endfunction

   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      case (csr_paddr[3:2])
         apct_pkg::REG_AREA:   csr_prdata = {31'd0, area_ff};
         apct_pkg::REG_MARGIN: csr_prdata = {24'd0, margin_ff};
         apct_pkg::REG_FLOOR:  csr_prdata = {{16{floor_ff[15]}}, floor_ff};
         default:              csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         area_ff   <= 1'b1;
         margin_ff <= 8'd30;
         floor_ff  <= 16'sd0;
      end else if (cfg_wr) begin
         case (csr_paddr[3:2])
            apct_pkg::REG_AREA:   area_ff   <= csr_pwdata[0];
            apct_pkg::REG_MARGIN: margin_ff <= csr_pwdata[7:0];
            apct_pkg::REG_FLOOR:  floor_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   apct_extent u_extent (
      .clock(clock), .model(model_ff), .rotation(rot_ff), .half_x(hx), .half_z(hz)
   );

   assign wr_data = '{x: px_ff, y: py_ff, z: pz_ff, hx: hx, hz: hz,
                      h: apct_pkg::DIM_H[model_ff]};

   apct_table #(.DEPTH(MAX_PROPS), .AW(AW)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_addr(total_ff[AW-1:0]), .wr_data(wr_data),
      .rd_addr(idx_ff[AW-1:0]), .rd_data(rd_data)
   );

   assign req_tready = (state_ff == apct_pkg::ST_IDLE);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;

   // combinational test of one prop
   logic signed [18:0] wx, wz, lox, hix, loz, hiz, pl, pr, pf, pb, best, dx, dz;
   logic signed [18:0] base, ylo, qwx, qwz;
   logic               cin, qin;
   always_comb begin
      wx = 19'(rd_data.hx) + 19'(rad_ff) + 19'(margin_ff);
      wz = 19'(rd_data.hz) + 19'(rad_ff) + 19'(margin_ff);
      lox = 19'(rd_data.x) - wx; hix = 19'(rd_data.x) + wx;
      loz = 19'(rd_data.z) - wz; hiz = 19'(rd_data.z) + wz;
      cin = nx_ff > lox && nx_ff < hix && nz_ff > loz && nz_ff < hiz;
      pl = nx_ff - lox; pr = hix - nx_ff; pf = nz_ff - loz; pb = hiz - nz_ff;
      best = pl; dx = -pl; dz = '0;
      if (pr < best) begin best = pr; dx = pr; dz = '0; end
      if (pf < best) begin best = pf; dx = '0; dz = -pf; end
      if (pb < best) begin dx = '0; dz = pb; end
      base = 19'(rd_data.y) + 19'(floor_ff);
      ylo  = base - 19'(rd_data.h);
      qwx  = 19'(rd_data.hx) + 19'(slk_ff);
      qwz  = 19'(rd_data.hz) + 19'(slk_ff);
      qin = 19'(py_ff) >= ylo && 19'(py_ff) <= base
         && 19'(px_ff) >= 19'(rd_data.x) - qwx
         && 19'(px_ff) <= 19'(rd_data.x) + qwx
         && 19'(pz_ff) >= 19'(rd_data.z) - qwz
         && 19'(pz_ff) <= 19'(rd_data.z) + qwz;
   end

   always_comb begin
      state_in = state_ff;
      nx_in = nx_ff; nz_in = nz_ff; hit_in = hit_ff; drop_in = drop_ff;
      total_in = total_ff; idx_in = idx_ff; calc_in = calc_ff;
      out_v_in = out_v_ff && !rsp_tready;
      out_d_in = out_d_ff;
      wr_en = 1'b0;
      case (state_ff)
         apct_pkg::ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               nx_in = 19'($signed(req_tdata[18:3]));
               nz_in = 19'($signed(req_tdata[50:35]));
               hit_in = 1'b0; drop_in = 1'b0; idx_in = '0; calc_in = 2'd3;
               case (apct_pkg::op_type'(req_tdata[1:0]))
                  apct_pkg::OP_CLEAR: begin
                     total_in = '0;
                     state_in = apct_pkg::ST_DONE;
                  end
                  apct_pkg::OP_APPEND: state_in = apct_pkg::ST_TRIG;
                  default: state_in = apct_pkg::ST_READ;
               endcase
            end
         end
         apct_pkg::ST_TRIG: begin
            if (calc_ff != 2'd0) begin
               calc_in = calc_ff - 2'd1;
            end else begin
               if (total_ff >= 7'(MAX_PROPS)) begin
                  drop_in = 1'b1;
               end else begin
                  wr_en = 1'b1;
                  total_in = total_ff + 7'd1;
               end
               state_in = apct_pkg::ST_DONE;
            end
         end
         apct_pkg::ST_READ: begin
            if (!area_ff || idx_ff >= total_ff || hit_ff) state_in = apct_pkg::ST_DONE;
            else state_in = apct_pkg::ST_TEST;
         end
         apct_pkg::ST_TEST: begin
            if (op_ff == apct_pkg::OP_COLLIDE) begin
               if (cin) begin
                  nx_in = nx_ff + dx;
                  nz_in = nz_ff + dz;
               end
            end else if (qin) begin
               hit_in = 1'b1;
            end
            idx_in = idx_ff + 7'd1;
            state_in = apct_pkg::ST_READ;
         end
         apct_pkg::ST_DONE: begin
            if (!out_v_ff) begin
               out_v_in = 1'b1;
               out_d_in = {7'd0, total_ff, drop_ff, hit_ff, sat16(nz_ff), sat16(nx_ff)};
               state_in = apct_pkg::ST_IDLE;
            end
         end
         default: state_in = apct_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= apct_pkg::ST_IDLE;
         total_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      nx_ff <= nx_in; nz_ff <= nz_in; hit_ff <= hit_in; drop_ff <= drop_in;
      idx_ff <= idx_in; calc_ff <= calc_in; out_d_ff <= out_d_in;
      if (req_tvalid && req_tready) begin
         op_ff    <= req_tdata[1:0];
         model_ff <= req_tdata[2];
         px_ff    <= req_tdata[18:3];
         py_ff    <= req_tdata[34:19];
         pz_ff    <= req_tdata[50:35];
         rot_ff   <= req_tdata[62:51];
         rad_ff   <= req_tdata[74:63];
         slk_ff   <= req_tdata[86:75];
      end
   end
endmodule

/* design/apct_extent.sv */
module apct_extent (
   input  logic        clock,
   input  logic        model,
   input  logic [11:0] rotation,
   output logic [8:0]  half_x,
   output logic [8:0]  half_z
);
   logic [14:0] x2c_ff, x2s_ff, x2c_in, x2s_in;
   logic [14:0] x2c_d_ff, x2s_d_ff;
   logic [14:0] yc_ff, ys_ff, yc_in, ys_in;
   logic [12:0] cos_ff, sin_ff, cos_in, sin_in;
   logic [20:0] ax, az;

   // fold the angle to -1024..1023 around the peak, square and scale
   function automatic logic [14:0] fold_square(input logic [11:0] ang);
      logic signed [10:0] t;
      logic signed [21:0] sq;
      t = $signed(11'(ang - 12'd1024));
      sq = 22'(t) * 22'(t);
      fold_square = sq[20:6];
   endfunction

   function automatic logic [14:0] poly(input logic [14:0] x2);
      logic [26:0] m1;
      m1 = 27'(x2) * 27'd3516;
      poly = 15'd19900 - 15'(m1 >> 14);
   endfunction

   function automatic logic [12:0] magnitude(input logic [14:0] x2, input logic [14:0] y);
      logic [29:0] m2;
      m2 = 30'(x2) * 30'(y);
      magnitude = 13'd4096 - 13'(m2 >> 16);
   endfunction

   assign x2c_in = fold_square(12'(rotation + 12'd1024));
   assign x2s_in = fold_square(rotation);
   assign yc_in  = poly(x2c_ff);
   assign ys_in  = poly(x2s_ff);
   assign cos_in = magnitude(x2c_d_ff, yc_ff);
   assign sin_in = magnitude(x2s_d_ff, ys_ff);

   always_ff @(posedge clock) begin
      x2c_ff   <= x2c_in;
      x2s_ff   <= x2s_in;
      x2c_d_ff <= x2c_ff;
      x2s_d_ff <= x2s_ff;
      yc_ff    <= yc_in;
      ys_ff    <= ys_in;
      cos_ff   <= cos_in;
      sin_ff   <= sin_in;
   end

   assign ax = 21'(apct_pkg::DIM_W[model]) * 21'(cos_ff)
             + 21'(apct_pkg::DIM_D[model]) * 21'(sin_ff);
   assign az = 21'(apct_pkg::DIM_W[model]) * 21'(sin_ff)
             + 21'(apct_pkg::DIM_D[model]) * 21'(cos_ff);
   assign half_x = ax[20:12];
   assign half_z = az[20:12];
endmodule

/* design/apct_table.sv */
module apct_table #(
   parameter int DEPTH = 8,
   parameter int AW = 3
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  apct_pkg::prop_type  wr_data,
   input  logic [AW-1:0]       rd_addr,
   output apct_pkg::prop_type  rd_data
);
   apct_pkg::prop_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
